FILE: src/jltf_pkg.sv
// Shared types, codes and constants of the jerk-limited joint trajectory filter.
package jltf_pkg;

  localparam int JOINT_W    = 3;
  localparam int POS_W      = 32;
  localparam int DT_W       = 24;
  localparam int GAIN_W     = 26;
  localparam int LIM_W      = 31;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int MUL_A_W    = 33;
  localparam int MUL_B_W    = 27;
  localparam int PROD_W     = 60;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_STREAM = 2'd1,
    CMD_STOP   = 2'd2
  } cmd_t;

  localparam logic [CFG_ADDR_W-1:0] REG_POS_GAIN   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_VEL_GAIN   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_VEL_LIMIT  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_ACC_LIMIT  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_JERK_LIMIT = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_VEL_QUIET  = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_ACC_QUIET  = 3'd6;

  localparam logic [GAIN_W-1:0] RST_POS_GAIN   = 26'd2359296;
  localparam logic [GAIN_W-1:0] RST_VEL_GAIN   = 26'd786432;
  localparam logic [LIM_W-1:0]  RST_VEL_LIMIT  = 31'd25165824;
  localparam logic [LIM_W-1:0]  RST_ACC_LIMIT  = 31'd100663296;
  localparam logic [LIM_W-1:0]  RST_JERK_LIMIT = 31'd838860800;
  localparam logic [LIM_W-1:0]  RST_VEL_QUIET  = 31'd1678;
  localparam logic [LIM_W-1:0]  RST_ACC_QUIET  = 31'd16777;

  localparam logic [DT_W-1:0] DT_FLOOR = 24'd17;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH,
    ST_MUL_P,
    ST_MUL_D,
    ST_MUL_J,
    ST_CLAMP,
    ST_DIFF,
    ST_ACC,
    ST_MUL_A,
    ST_VEL,
    ST_QUIET,
    ST_MUL_V,
    ST_POS,
    ST_WB
  } state_t;

  typedef enum logic [2:0] {
    MOP_NONE,
    MOP_ERR_KP,
    MOP_VEL_KV,
    MOP_JERK_DT,
    MOP_ACC_DT,
    MOP_VEL_DT
  } mop_t;

  typedef struct packed {
    logic [GAIN_W-1:0] pos_gain;
    logic [GAIN_W-1:0] vel_gain;
    logic [LIM_W-1:0]  vel_limit;
    logic [LIM_W-1:0]  acc_limit;
    logic [LIM_W-1:0]  jerk_limit;
    logic [LIM_W-1:0]  vel_quiet;
    logic [LIM_W-1:0]  acc_quiet;
  } cfg_t;

  typedef struct packed {
    logic in_ready;
    logic fetch;
    mop_t mop;
    logic sum_load;
    logic sum_sub;
    logic des_en;
    logic diff_en;
    logic acc_en;
    logic vel_en;
    logic quiet_en;
    logic pos_en;
    logic wb;
  } ctl_t;

  typedef struct packed {
    cmd_t cmd;
    logic joint_ok;
    logic out_free;
  } sts_t;

endpackage

FILE: src/jerk_limited_joint_trajectory_filter.sv
// Top level of the jerk-limited joint trajectory filter: joint state and datapath.
//
// Each input beat names a joint and a command: load a position, run one stream
// tick toward the joint's target, or run one stop tick that damps velocity with no position term.
// Every input beat yields exactly one output beat with the joint's new position,
// velocity and acceleration, plus a quiet flag when a stop tick brought the joint
// to rest. Joints outside the configured count report zeros and change nothing.
// Gains and limits are written over the cfg channel, which is always ready; the user
// must write them only while no item is in flight, as the block does not enforce it.
// All multiplication runs through one 33 x 27 bit signed multiplier under a step
// sequencer; the multiplier is used five times per tick. An item is accepted
// only while the sequencer is idle, so a new beat waits until the previous item
// has been written back. A stop tick adds a quiet-check step to the steps of a
// stream tick; a load, the unused command or an out-of-range joint goes straight
// from fetch to write-back.
// The result sits in an output register: while the receiver stalls the next item
// is still accepted and computed, and only its write-back waits for the slot.
// Reset clears all joint state to zero and restores the default gains and limits.
module jerk_limited_joint_trajectory_filter #(
  parameter int NUM_JOINTS = 7
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // joint[2:0], position_in[34:3], tick_seconds[58:35], zero fill above
  input  logic [63:0]  in_tdata,
  // cmd[1:0], new_target_valid[2], zero fill above
  input  logic [7:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // joint_out[2:0], position_out[34:3], velocity_out[66:35], accel_out[98:67],
  // quiet[99], zero fill above
  output logic [103:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_addr,
  input  logic [31:0]  cfg_data
);
  import jltf_pkg::*;

  localparam int IDX_W = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
  localparam logic [4:0] NJ = 5'(NUM_JOINTS);

  cfg_t cfg;
  ctl_t ctl;
  sts_t sts;

  // Item registers.
  cmd_t                cmd_r;
  logic [JOINT_W-1:0]  joint_r;
  logic                tv_r;
  logic signed [31:0]  pin_r;
  logic [DT_W-1:0]     dt_r;

  // Working registers.
  logic signed [31:0]  pos_r, vel_r, acc_r, tgt_r, des_r;
  logic signed [59:0]  sum_r;
  logic signed [32:0]  diff_r;
  logic [LIM_W-1:0]    maxda_r;
  logic                quiet_r;

  // Joint state.
  logic signed [31:0]  pos_mem_r [NUM_JOINTS];
  logic signed [31:0]  vel_mem_r [NUM_JOINTS];
  logic signed [31:0]  acc_mem_r [NUM_JOINTS];
  logic signed [31:0]  tgt_mem_r [NUM_JOINTS];

  // Output slot.
  logic                out_valid_r;
  logic [JOINT_W-1:0]  out_joint_r;
  logic [31:0]         out_pos_r, out_vel_r, out_acc_r;
  logic                out_quiet_r;

  logic [4:0]          jidx_w;
  logic [IDX_W-1:0]    idx;
  logic                joint_ok;
  logic [DT_W-1:0]     tick_w;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [32:0]        err_w;

  logic signed [43:0]  des_sh, amax44, des_c;
  logic signed [32:0]  mda33, da_w, acc_sum;
  logic signed [35:0]  inc36;
  logic signed [36:0]  vsum, vmax37, vel_c, psum, pos_c;
  logic signed [32:0]  vel33, acc33, vabs, aabs;
  logic                is_quiet;

  localparam logic signed [36:0] PMAX = 37'sh0_7FFF_FFFF;
  localparam logic signed [36:0] PMIN = -37'sh0_8000_0000;

  jltf_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  jltf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .sts      (sts),
    .ctl      (ctl)
  );

  jltf_mul u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod_r)
  );

  assign in_tready = ctl.in_ready;
  assign tick_w    = in_tdata[58:35];

  assign jidx_w   = {2'b00, joint_r};
  assign idx      = jidx_w[IDX_W-1:0];
  assign joint_ok = (jidx_w < NJ);

  assign sts.cmd      = cmd_r;
  assign sts.joint_ok = joint_ok;
  assign sts.out_free = !out_valid_r || out_tready;

  // Multiplier operand selection.
  assign err_w = {tgt_r[31], tgt_r} - {pos_r[31], pos_r};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctl.mop)
      MOP_ERR_KP: begin
        // A stop tick has no position term.
        mul_a = (cmd_r == CMD_STREAM) ? err_w : '0;
        mul_b = {1'b0, cfg.pos_gain};
      end
      MOP_VEL_KV: begin
        mul_a = {vel_r[31], vel_r};
        mul_b = {1'b0, cfg.vel_gain};
      end
      MOP_JERK_DT: begin
        mul_a = {2'b00, cfg.jerk_limit};
        mul_b = {3'b000, dt_r};
      end
      MOP_ACC_DT: begin
        mul_a = {acc_r[31], acc_r};
        mul_b = {3'b000, dt_r};
      end
      MOP_VEL_DT: begin
        mul_a = {vel_r[31], vel_r};
        mul_b = {3'b000, dt_r};
      end
      default: begin
      end
    endcase
  end

  // Desired acceleration, floored and clamped to the acceleration limit.
  assign des_sh = sum_r[59:16];
  assign amax44 = {13'b0, cfg.acc_limit};
  always_comb begin
    if (des_sh > amax44) begin
      des_c = amax44;
    end else if (des_sh < -amax44) begin
      des_c = -amax44;
    end else begin
      des_c = des_sh;
    end
  end

  // Acceleration step limited by jerk times dt.
  assign mda33 = {2'b00, maxda_r};
  always_comb begin
    if (diff_r > mda33) begin
      da_w = mda33;
    end else if (diff_r < -mda33) begin
      da_w = -mda33;
    end else begin
      da_w = diff_r;
    end
  end
  assign acc_sum = {acc_r[31], acc_r} + da_w;

  // Velocity and position increments share the floored product scaling.
  assign inc36  = prod_r[59:24];
  assign vsum   = {{5{vel_r[31]}}, vel_r} + {inc36[35], inc36};
  assign vmax37 = {6'b0, cfg.vel_limit};
  always_comb begin
    if (vsum > vmax37) begin
      vel_c = vmax37;
    end else if (vsum < -vmax37) begin
      vel_c = -vmax37;
    end else begin
      vel_c = vsum;
    end
  end

  assign psum = {{5{pos_r[31]}}, pos_r} + {inc36[35], inc36};
  always_comb begin
    if (psum > PMAX) begin
      pos_c = PMAX;
    end else if (psum < PMIN) begin
      pos_c = PMIN;
    end else begin
      pos_c = psum;
    end
  end

  assign vel33    = {vel_r[31], vel_r};
  assign acc33    = {acc_r[31], acc_r};
  assign vabs     = vel33[32] ? -vel33 : vel33;
  assign aabs     = acc33[32] ? -acc33 : acc33;
  assign is_quiet = ($unsigned(vabs) < {2'b00, cfg.vel_quiet}) &&
                    ($unsigned(aabs) < {2'b00, cfg.acc_quiet});

  // Item capture and working registers.
  always_ff @(posedge clk) begin
    if (in_tvalid && ctl.in_ready) begin
      cmd_r   <= cmd_t'(in_tuser[1:0]);
      tv_r    <= in_tuser[2];
      joint_r <= in_tdata[2:0];
      pin_r   <= in_tdata[34:3];
      dt_r    <= (tick_w < DT_FLOOR) ? DT_FLOOR : tick_w;
    end

    if (ctl.fetch) begin
      quiet_r <= 1'b0;
      if (!joint_ok) begin
        pos_r <= '0;
        vel_r <= '0;
        acc_r <= '0;
        tgt_r <= '0;
      end else if (cmd_r == CMD_LOAD) begin
        pos_r <= pin_r;
        vel_r <= '0;
        acc_r <= '0;
        tgt_r <= pin_r;
      end else begin
        pos_r <= pos_mem_r[idx];
        vel_r <= vel_mem_r[idx];
        acc_r <= acc_mem_r[idx];
        tgt_r <= (cmd_r == CMD_STREAM && tv_r) ? pin_r : tgt_mem_r[idx];
      end
    end

    if (ctl.sum_load) sum_r <= prod_r;
    if (ctl.sum_sub)  sum_r <= sum_r - prod_r;

    if (ctl.des_en) begin
      des_r   <= des_c[31:0];
      maxda_r <= prod_r[54:24];
    end

    if (ctl.diff_en) diff_r <= {des_r[31], des_r} - {acc_r[31], acc_r};
    if (ctl.acc_en)  acc_r  <= acc_sum[31:0];
    if (ctl.vel_en)  vel_r  <= vel_c[31:0];

    if (ctl.quiet_en && is_quiet) begin
      vel_r   <= '0;
      acc_r   <= '0;
      quiet_r <= 1'b1;
    end

    if (ctl.pos_en) pos_r <= pos_c[31:0];
  end

  // Joint state write-back.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_JOINTS; i++) begin
        pos_mem_r[i] <= '0;
        vel_mem_r[i] <= '0;
        acc_mem_r[i] <= '0;
        tgt_mem_r[i] <= '0;
      end
    end else if (ctl.wb && joint_ok) begin
      pos_mem_r[idx] <= pos_r;
      vel_mem_r[idx] <= vel_r;
      acc_mem_r[idx] <= acc_r;
      tgt_mem_r[idx] <= tgt_r;
    end
  end

  // Output slot.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.wb) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wb) begin
      out_joint_r <= joint_r;
      out_pos_r   <= pos_r;
      out_vel_r   <= vel_r;
      out_acc_r   <= acc_r;
      out_quiet_r <= quiet_r && joint_ok;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_quiet_r, out_acc_r, out_vel_r, out_pos_r, out_joint_r};

endmodule

FILE: src/jltf_cfg.sv
// Configuration register file with its write channel.
module jltf_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [jltf_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [jltf_pkg::CFG_DATA_W-1:0]     cfg_data,
  output jltf_pkg::cfg_t                      cfg
);
  import jltf_pkg::*;

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pos_gain   <= RST_POS_GAIN;
      cfg_r.vel_gain   <= RST_VEL_GAIN;
      cfg_r.vel_limit  <= RST_VEL_LIMIT;
      cfg_r.acc_limit  <= RST_ACC_LIMIT;
      cfg_r.jerk_limit <= RST_JERK_LIMIT;
      cfg_r.vel_quiet  <= RST_VEL_QUIET;
      cfg_r.acc_quiet  <= RST_ACC_QUIET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        REG_POS_GAIN:   cfg_r.pos_gain   <= cfg_data[GAIN_W-1:0];
        REG_VEL_GAIN:   cfg_r.vel_gain   <= cfg_data[GAIN_W-1:0];
        REG_VEL_LIMIT:  cfg_r.vel_limit  <= cfg_data[LIM_W-1:0];
        REG_ACC_LIMIT:  cfg_r.acc_limit  <= cfg_data[LIM_W-1:0];
        REG_JERK_LIMIT: cfg_r.jerk_limit <= cfg_data[LIM_W-1:0];
        REG_VEL_QUIET:  cfg_r.vel_quiet  <= cfg_data[LIM_W-1:0];
        REG_ACC_QUIET:  cfg_r.acc_quiet  <= cfg_data[LIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: src/jltf_mul.sv
// Shared signed multiplier with a registered product.
module jltf_mul (
  input  logic                                   clk,
  input  logic signed [jltf_pkg::MUL_A_W-1:0]    mul_a,
  input  logic signed [jltf_pkg::MUL_B_W-1:0]    mul_b,
  output logic signed [jltf_pkg::PROD_W-1:0]     prod_r
);
  import jltf_pkg::*;

  logic signed [PROD_W-1:0] prod_nxt;

  assign prod_nxt = mul_a * mul_b;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

FILE: src/jltf_ctrl.sv
// Step sequencer that drives the shared multiplier and the datapath.
module jltf_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  jltf_pkg::sts_t sts,
  output jltf_pkg::ctl_t ctl
);
  import jltf_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_FETCH;
      end
      ST_FETCH: begin
        // Loads, the unused code and joints out of range need no arithmetic.
        if (sts.joint_ok && (sts.cmd == CMD_STREAM || sts.cmd == CMD_STOP)) begin
          state_nxt = ST_MUL_P;
        end else begin
          state_nxt = ST_WB;
        end
      end
      ST_MUL_P: state_nxt = ST_MUL_D;
      ST_MUL_D: state_nxt = ST_MUL_J;
      ST_MUL_J: state_nxt = ST_CLAMP;
      ST_CLAMP: state_nxt = ST_DIFF;
      ST_DIFF:  state_nxt = ST_ACC;
      ST_ACC:   state_nxt = ST_MUL_A;
      ST_MUL_A: state_nxt = ST_VEL;
      ST_VEL: begin
        if (sts.cmd == CMD_STOP) begin
          state_nxt = ST_QUIET;
        end else begin
          state_nxt = ST_MUL_V;
        end
      end
      ST_QUIET: state_nxt = ST_MUL_V;
      ST_MUL_V: state_nxt = ST_POS;
      ST_POS:   state_nxt = ST_WB;
      ST_WB: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    ctl.mop = MOP_NONE;
    case (state_r)
      ST_IDLE:  ctl.in_ready = 1'b1;
      ST_FETCH: ctl.fetch = 1'b1;
      ST_MUL_P: ctl.mop = MOP_ERR_KP;
      ST_MUL_D: begin
        ctl.mop      = MOP_VEL_KV;
        ctl.sum_load = 1'b1;
      end
      ST_MUL_J: begin
        ctl.mop     = MOP_JERK_DT;
        ctl.sum_sub = 1'b1;
      end
      ST_CLAMP: ctl.des_en = 1'b1;
      ST_DIFF:  ctl.diff_en = 1'b1;
      ST_ACC:   ctl.acc_en = 1'b1;
      ST_MUL_A: ctl.mop = MOP_ACC_DT;
      ST_VEL:   ctl.vel_en = 1'b1;
      ST_QUIET: ctl.quiet_en = 1'b1;
      ST_MUL_V: ctl.mop = MOP_VEL_DT;
      ST_POS:   ctl.pos_en = 1'b1;
      ST_WB:    ctl.wb = sts.out_free;
      default: begin
      end
    endcase
  end

endmodule

FILE: src/jltf_chk.sv
// Port-level checker for the trajectory filter, bound to the top level.
module jltf_chk #(
  parameter int NUM_JOINTS = 7
) (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [103:0] out_tdata
);

  localparam logic [4:0] NJ = 5'(NUM_JOINTS);

  logic in_beat;
  assign in_beat = in_tvalid && in_tready;

  // One item at a time: the input side closes right after a beat.
  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> !in_tready)
    else $error("input accepted again right after a beat");

  // No result can appear the cycle right after its input beat.
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_beat))
    else $error("result appeared too early");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // Joints beyond the configured count report zeros in every field above the joint number.
  a_bad_joint_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && ({2'b00, out_tdata[2:0]} >= NJ)) |-> (out_tdata[103:3] == '0))
    else $error("out-of-range joint reported nonzero motion");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled output beat changed");

endmodule

bind jerk_limited_joint_trajectory_filter jltf_chk #(.NUM_JOINTS(NUM_JOINTS)) u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
